// ===== hdl/mbid_pkg.sv =====
// ----------------------------------------------------------------------------
// mbid_pkg
// Types and codes shared by the multi-button integrator debounce unit.
// ----------------------------------------------------------------------------
package mbid_pkg;

  // input item action codes
  localparam logic [1:0] ACT_SAMPLE   = 2'd0;
  localparam logic [1:0] ACT_EVALUATE = 2'd1;
  localparam logic [1:0] ACT_ENABLE   = 2'd2;
  localparam logic [1:0] ACT_DISABLE  = 2'd3;

  // report event codes
  localparam logic [1:0] EV_PRESSED  = 2'd0;
  localparam logic [1:0] EV_HELD     = 2'd1;
  localparam logic [1:0] EV_RELEASED = 2'd2;

  localparam logic [7:0] INTEGRATOR_MAX_RESET = 8'd10;
  localparam int unsigned MAX_REPORTS = 8;

  // per-button state word kept in the state memory
  typedef struct packed {
    logic [7:0]  integ;
    logic [15:0] count;
    logic        level;
  } entry_t;

endpackage

// ===== hdl/mbid_state_ram.sv =====
// ----------------------------------------------------------------------------
// mbid_state_ram
// Per-button state memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mbid_state_ram #(
  parameter int NUM_ENTRIES = 8
) (
  input  logic                                                    clk,
  input  logic                                                    wr_en,
  input  logic [(NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1)-1:0]  wr_addr,
  input  mbid_pkg::entry_t                                        wr_data,
  input  logic                                                    rd_en,
  input  logic [(NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1)-1:0]  rd_addr,
  output mbid_pkg::entry_t                                        rd_data
);
  import mbid_pkg::*;

  entry_t mem [NUM_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/multi_button_integrator_debounce_unit.sv =====
// ----------------------------------------------------------------------------
// multi_button_integrator_debounce_unit
// Debounces up to NUM_BUTTONS buttons with saturating integrators.
// ----------------------------------------------------------------------------
// Each button keeps an 8-bit integrator, a 16-bit hold count and a debounced
// level in a single-port-read state memory; enable flags sit in flip-flops.
// Sample and evaluate items scan the buttons one per cycle through the
// memory read port, except while a new report waits on a stalled report
// side. Evaluate reports leave in button id order, at most eight per item,
// the final one flagged with last. The item side is stalled while a scan or
// its report flush runs; integrator_max may be written whenever the block
// is idle.
// ----------------------------------------------------------------------------
module multi_button_integrator_debounce_unit #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: integrator_max
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  pin_levels,
  input  logic [2:0]  button_id,
  // report channel
  output logic        report_valid,
  input  logic        report_stall,
  output logic [2:0]  report_id,
  output logic [1:0]  event_res,
  output logic [15:0] hold_count,
  output logic        debounced_level,
  output logic        last
);
  import mbid_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int CNT_W = $clog2(NUM_BUTTONS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]             state;
  logic                   op_eval;
  logic [7:0]             pins;
  logic [7:0]             imax;
  logic [NUM_BUTTONS-1:0] enabled;
  logic [CNT_W-1:0]       rd_idx;
  logic [CNT_W-1:0]       stage_idx;
  logic                   stage_valid;
  logic [3:0]             rep_cnt;

  logic                   pend_valid;
  logic [2:0]             pend_id;
  logic [1:0]             pend_ev;
  logic [15:0]            pend_count;
  logic                   pend_level;

  logic                   item_accept;
  logic [5:0]             bid6;
  logic                   id_ok;
  logic [5:0]             sidx6;
  logic                   stage_en;
  logic                   pin_hi;
  logic                   more;
  entry_t                 cur;
  entry_t                 upd;
  logic                   rep;
  logic [1:0]             ev;
  logic                   emit;
  logic                   out_free;
  logic                   blocked;
  logic                   scan_go;
  logic                   load_mid;
  logic                   load_end;

  logic                   ram_wr_en;
  logic [IDX_W-1:0]       ram_wr_addr;
  entry_t                 ram_wr_data;
  logic                   ram_rd_en;
  logic [IDX_W-1:0]       ram_rd_addr;

  mbid_state_ram #(
    .NUM_ENTRIES (NUM_BUTTONS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (cur)
  );

  assign cfg_ready   = 1'b1;
  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;

  assign bid6     = 6'(button_id);
  assign id_ok    = (bid6 < 6'(NUM_BUTTONS));
  assign sidx6    = 6'(stage_idx);
  assign stage_en = enabled[stage_idx[IDX_W-1:0]];
  // buttons past the pin vector see a low pin
  assign pin_hi   = (sidx6 < 6'd8) && pins[sidx6[2:0]];
  assign more     = (rd_idx < CNT_W'(NUM_BUTTONS));

  always_comb begin
    upd = cur;
    rep = 1'b0;
    ev  = EV_PRESSED;
    if (!op_eval) begin
      if (!pin_hi) begin
        if (cur.integ != 8'd0) begin
          upd.integ = cur.integ - 8'd1;
        end
      end else if (cur.integ < imax) begin
        upd.integ = cur.integ + 8'd1;
      end
    end else begin
      if (cur.integ == imax) begin
        ev        = cur.level ? EV_HELD : EV_PRESSED;
        rep       = 1'b1;
        upd.count = cur.count + 16'd1;
        upd.level = 1'b1;
      end else if (cur.integ == 8'd0) begin
        ev        = EV_RELEASED;
        rep       = cur.level;
        upd.count = 16'd0;
        upd.level = 1'b0;
      end
    end
  end

  assign emit     = stage_valid && stage_en && rep && (rep_cnt < 4'(MAX_REPORTS));
  assign out_free = !report_valid || !report_stall;
  // a new report needs the pending one moved out first
  assign blocked  = emit && pend_valid && !out_free;
  assign scan_go  = (state == ST_SCAN) && !blocked;
  assign load_mid = scan_go && emit && pend_valid;
  assign load_end = (state == ST_FLUSH) && pend_valid && out_free;

  // scan reads index i while writing back i-1, so the ports never collide
  always_comb begin
    ram_rd_en   = scan_go && more;
    ram_rd_addr = rd_idx[IDX_W-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = stage_idx[IDX_W-1:0];
    ram_wr_data = upd;
    if (item_accept && (action == ACT_ENABLE) && id_ok) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = bid6[IDX_W-1:0];
      ram_wr_data = '0;
    end else if (scan_go && stage_valid && stage_en) begin
      ram_wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      imax <= INTEGRATOR_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      imax <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      enabled     <= '0;
      rd_idx      <= '0;
      stage_valid <= 1'b0;
      rep_cnt     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_accept) begin
            case (action) inside
              ACT_SAMPLE, ACT_EVALUATE: begin
                state   <= ST_SCAN;
                rd_idx  <= '0;
                rep_cnt <= '0;
              end
              ACT_ENABLE: begin
                if (id_ok) begin
                  enabled[bid6[IDX_W-1:0]] <= 1'b1;
                end
              end
              default: begin
                if (id_ok) begin
                  enabled[bid6[IDX_W-1:0]] <= 1'b0;
                end
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_go) begin
            if (emit) begin
              rep_cnt <= rep_cnt + 4'd1;
            end
            if (more) begin
              rd_idx      <= rd_idx + CNT_W'(1);
              stage_valid <= 1'b1;
            end else begin
              stage_valid <= 1'b0;
              state       <= op_eval ? ST_FLUSH : ST_IDLE;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      op_eval <= (action == ACT_EVALUATE);
      pins    <= pin_levels;
    end
    if (scan_go && more) begin
      stage_idx <= rd_idx;
    end
  end

  // one report held back until the next one shows whether it is the last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (scan_go && emit) begin
      pend_valid <= 1'b1;
    end else if (load_end) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_go && emit) begin
      pend_id    <= sidx6[2:0];
      pend_ev    <= ev;
      pend_count <= upd.count;
      pend_level <= upd.level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (load_mid || load_end) begin
      report_valid <= 1'b1;
    end else if (!report_stall) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid || load_end) begin
      report_id       <= pend_id;
      event_res       <= pend_ev;
      hold_count      <= pend_count;
      debounced_level <= pend_level;
      last            <= load_end;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending report left over in idle");

  a_stage_in_scan: assert property (@(posedge clk) disable iff (rst)
    stage_valid |-> (state == ST_SCAN))
    else $error("scan stage valid outside a scan");

  a_port_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
    else $error("state memory read and write hit the same entry");

  a_report_cap: assert property (@(posedge clk) disable iff (rst)
    rep_cnt <= 4'(MAX_REPORTS))
    else $error("more reports than allowed in one evaluate item");

endmodule
